// ----- design/tsm_pkg.sv -----
// shared types and constants for the thread scheduler with mutexes
// no dependencies; every other design file but tsm_ram refers to it by scoped names
package tsm_pkg;

  // default sizes of the slot pool and the mutex bank
  localparam int THREAD_SLOTS_DEF = 4;
  localparam int MUTEX_COUNT_DEF  = 4;

  // field widths of the input and result transactions
  localparam int CMD_W     = 3;
  localparam int MUTEX_W   = 2;
  localparam int ENTRY_W   = 16;
  localparam int ARG_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int RUN_W     = 3;
  localparam int SPAWN_W   = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN  = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_LOCK   = 3'd2,
    CMD_UNLOCK = 3'd3,
    CMD_EXIT   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NO_FREE  = 3'd1,
    STS_NO_READY = 3'd2,
    STS_HALTED   = 3'd3,
    STS_BAD_EXIT = 3'd4
  } status_e;

  // which linked queue an operation acts on
  typedef enum logic [1:0] {
    Q_FREE  = 2'd0,
    Q_READY = 2'd1,
    Q_WAIT  = 2'd2
  } qsel_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECIDE = 3'd1,
    ST_POP    = 3'd2,
    ST_PUSH   = 3'd3,
    ST_SLOT   = 3'd4,
    ST_OUT    = 3'd5
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decide;
    logic pop_upd;
    logic push_link;
    logic slot_rd;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_go;
  } dp_stat_t;

endpackage

// ----- design/thread_scheduler_with_mutex_top.sv -----
// a command passes the capture, decide, slot store read and output steps; the pop
// and push steps come after decide when a thread moves between queues (pop then
// push through the link table ram); a new command is accepted only after the output
// step, and a stalled result holds the next command in its output step
// reset: asynchronous, active low; free list holds all slots in order, the
// initial thread runs, every mutex is free and no result is pending
module thread_scheduler_with_mutex_top #(
  parameter int THREAD_SLOTS = tsm_pkg::THREAD_SLOTS_DEF,
  parameter int MUTEX_COUNT  = tsm_pkg::MUTEX_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tsm_pkg::CMD_W-1:0]        cmd_i,
  input  logic [tsm_pkg::MUTEX_W-1:0]      mutex_id_i,
  input  logic [tsm_pkg::ENTRY_W-1:0]      entry_addr_i,
  input  logic signed [tsm_pkg::ARG_W-1:0] arg_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tsm_pkg::STATUS_W-1:0]     status_o,
  output logic [tsm_pkg::RUN_W-1:0]        running_thread_o,
  output logic                             switched_o,
  output logic [tsm_pkg::SPAWN_W-1:0]      spawned_thread_o,
  output logic [tsm_pkg::ENTRY_W-1:0]      running_entry_o,
  output logic signed [tsm_pkg::ARG_W-1:0] running_arg_o
);

  tsm_pkg::dp_cmd_t  dp_cmd;
  tsm_pkg::dp_stat_t dp_stat;

  // sequencer
  tsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // queues, mutexes and result register
  tsm_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .MUTEX_COUNT  (MUTEX_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .cmd_in_i         (cmd_i),
    .mutex_id_i       (mutex_id_i),
    .entry_addr_i     (entry_addr_i),
    .arg_value_i      (arg_value_i),
    .status_o         (status_o),
    .running_thread_o (running_thread_o),
    .switched_o       (switched_o),
    .spawned_thread_o (spawned_thread_o),
    .running_entry_o  (running_entry_o),
    .running_arg_o    (running_arg_o)
  );

endmodule

// ----- design/tsm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tsm_ctrl.sv -----
// sequencing state machine of the thread scheduler
// depends on tsm_pkg for state, command and status types
module tsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tsm_pkg::dp_stat_t stat_i,
  output tsm_pkg::dp_cmd_t  cmd_o
);

  tsm_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      tsm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tsm_pkg::ST_DECIDE;
        end
      end
      tsm_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.op_go ? tsm_pkg::ST_POP : tsm_pkg::ST_SLOT;
      end
      tsm_pkg::ST_POP: begin
        cmd_o.pop_upd = 1'b1;
        state_d       = tsm_pkg::ST_PUSH;
      end
      tsm_pkg::ST_PUSH: begin
        cmd_o.push_link = 1'b1;
        state_d         = tsm_pkg::ST_SLOT;
      end
      tsm_pkg::ST_SLOT: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = tsm_pkg::ST_OUT;
      end
      tsm_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = tsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsm_pkg::ST_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != tsm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/tsm_datapath.sv -----
// queue pointers, mutex state, link and slot memories, result register
// depends on tsm_pkg and tsm_ram
module tsm_datapath #(
  parameter int THREAD_SLOTS = tsm_pkg::THREAD_SLOTS_DEF,
  parameter int MUTEX_COUNT  = tsm_pkg::MUTEX_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsm_pkg::dp_cmd_t                    cmd_i,
  output tsm_pkg::dp_stat_t                   stat_o,
  input  logic [tsm_pkg::CMD_W-1:0]           cmd_in_i,
  input  logic [tsm_pkg::MUTEX_W-1:0]         mutex_id_i,
  input  logic [tsm_pkg::ENTRY_W-1:0]         entry_addr_i,
  input  logic signed [tsm_pkg::ARG_W-1:0]    arg_value_i,
  output logic [tsm_pkg::STATUS_W-1:0]        status_o,
  output logic [tsm_pkg::RUN_W-1:0]           running_thread_o,
  output logic                                switched_o,
  output logic [tsm_pkg::SPAWN_W-1:0]         spawned_thread_o,
  output logic [tsm_pkg::ENTRY_W-1:0]         running_entry_o,
  output logic signed [tsm_pkg::ARG_W-1:0]    running_arg_o
);

  localparam int LINK_DEPTH = THREAD_SLOTS + 1;
  localparam int ID_W       = $clog2(THREAD_SLOTS + 2);
  localparam int LA_W       = $clog2(LINK_DEPTH);
  localparam int SA_W       = $clog2(THREAD_SLOTS);
  localparam int MI_W       = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int SLOT_W     = tsm_pkg::ENTRY_W + tsm_pkg::ARG_W;
  localparam logic [ID_W-1:0] NIL_ID  = ID_W'(THREAD_SLOTS + 1);
  localparam logic [ID_W-1:0] INIT_ID = ID_W'(THREAD_SLOTS);

  // reset contents of the link table: slots chained in order
  function automatic logic [ID_W-1:0] link_rst(input logic [LA_W-1:0] idx);
    logic [ID_W-1:0] res;
    res = NIL_ID;
    if (int'(idx) + 1 < THREAD_SLOTS) begin
      res = ID_W'(int'(idx) + 1);
    end
    return res;
  endfunction

  // latched transaction fields
  logic [tsm_pkg::CMD_W-1:0]   cmd_q;
  logic [tsm_pkg::MUTEX_W-1:0] m_q;
  logic [tsm_pkg::ENTRY_W-1:0] entry_q;
  logic [tsm_pkg::ARG_W-1:0]   arg_q;

  // scheduler state
  logic [ID_W-1:0]       free_head_q, free_tail_q;
  logic [ID_W-1:0]       ready_head_q, ready_tail_q;
  logic [ID_W-1:0]       wait_head_q [MUTEX_COUNT];
  logic [ID_W-1:0]       wait_tail_q [MUTEX_COUNT];
  logic [MUTEX_COUNT-1:0] locked_q;
  logic [ID_W-1:0]       cur_q, before_q, popped_q;
  logic                  halted_q;
  logic [LINK_DEPTH-1:0] link_vld_q;

  // per-transaction plan
  tsm_pkg::status_e status_q, status_d;
  tsm_pkg::qsel_e   pop_sel_q, pop_sel_d, push_sel_q, push_sel_d;
  logic             spawn_q, spawn_d, op_d;
  logic             lock_set_d, lock_clr_d;
  logic [ID_W-1:0]  pop_head_d;

  logic [MI_W-1:0]  m_idx;
  logic             m_ok;
  logic             ready_empty, wait_empty;

  // memory ports
  logic             link_we, link_re;
  logic [LA_W-1:0]  link_waddr;
  logic [ID_W-1:0]  link_wdata, link_rdata, link_val;
  logic             slot_we, slot_re;
  logic [SLOT_W-1:0] slot_rdata;

  // pop and push working values
  logic [ID_W-1:0]  pop_nh;
  logic             pop_empty;
  logic [ID_W-1:0]  push_id, push_head, push_tail;
  logic             push_empty;
  logic             cur_is_slot;

  assign m_idx       = MI_W'(m_q);
  assign m_ok        = (int'(m_q) < MUTEX_COUNT);
  assign ready_empty = (ready_head_q >= ID_W'(LINK_DEPTH));
  assign wait_empty  = (wait_head_q[m_idx] >= ID_W'(LINK_DEPTH));

  // command decision on the latched transaction
  always_comb begin
    status_d   = tsm_pkg::STS_OK;
    pop_sel_d  = tsm_pkg::Q_READY;
    push_sel_d = tsm_pkg::Q_READY;
    spawn_d    = 1'b0;
    op_d       = 1'b0;
    lock_set_d = 1'b0;
    lock_clr_d = 1'b0;
    if (halted_q) begin
      status_d = tsm_pkg::STS_HALTED;
    end else begin
      case (cmd_q)
        tsm_pkg::CMD_SPAWN: begin
          if (free_head_q >= INIT_ID) begin
            status_d = tsm_pkg::STS_NO_FREE;
          end else begin
            op_d      = 1'b1;
            spawn_d   = 1'b1;
            pop_sel_d = tsm_pkg::Q_FREE;
          end
        end
        tsm_pkg::CMD_YIELD: begin
          op_d = !ready_empty;
        end
        tsm_pkg::CMD_LOCK: begin
          if (m_ok) begin
            if (!locked_q[m_idx]) begin
              lock_set_d = 1'b1;
            end else if (ready_empty) begin
              status_d = tsm_pkg::STS_NO_READY;
            end else begin
              op_d       = 1'b1;
              push_sel_d = tsm_pkg::Q_WAIT;
            end
          end
        end
        tsm_pkg::CMD_UNLOCK: begin
          if (m_ok) begin
            if (!wait_empty) begin
              op_d      = 1'b1;
              pop_sel_d = tsm_pkg::Q_WAIT;
            end else begin
              lock_clr_d = 1'b1;
            end
          end
        end
        tsm_pkg::CMD_EXIT: begin
          if (cur_q >= INIT_ID) begin
            status_d = tsm_pkg::STS_BAD_EXIT;
          end else if (ready_empty) begin
            status_d = tsm_pkg::STS_NO_READY;
          end else begin
            op_d       = 1'b1;
            push_sel_d = tsm_pkg::Q_FREE;
          end
        end
        default: begin
          status_d = tsm_pkg::STS_OK;
        end
      endcase
    end
  end

  // head of the queue to pop from
  always_comb begin
    case (pop_sel_d)
      tsm_pkg::Q_FREE: pop_head_d = free_head_q;
      tsm_pkg::Q_WAIT: pop_head_d = wait_head_q[m_idx];
      default:         pop_head_d = ready_head_q;
    endcase
  end

  assign stat_o.op_go = op_d;

  // successor of the popped slot, with reset contents for unwritten entries
  assign link_val  = link_vld_q[popped_q[LA_W-1:0]] ? link_rdata
                                                     : link_rst(popped_q[LA_W-1:0]);
  assign pop_empty = (link_val >= ID_W'(LINK_DEPTH));
  assign pop_nh    = pop_empty ? NIL_ID : link_val;
  assign push_id   = spawn_q ? popped_q : cur_q;

  // push queue pointers as they stand after the pop
  always_comb begin
    case (push_sel_q)
      tsm_pkg::Q_FREE: begin
        push_head = free_head_q;
        push_tail = free_tail_q;
      end
      tsm_pkg::Q_WAIT: begin
        push_head = wait_head_q[m_idx];
        push_tail = wait_tail_q[m_idx];
      end
      default: begin
        push_head = ready_head_q;
        push_tail = ready_tail_q;
      end
    endcase
  end
  assign push_empty = (push_head >= ID_W'(LINK_DEPTH));

  // link table accesses
  assign link_re = cmd_i.decide && op_d;
  always_comb begin
    link_we    = 1'b0;
    link_waddr = push_id[LA_W-1:0];
    link_wdata = NIL_ID;
    if (cmd_i.pop_upd) begin
      link_we = 1'b1;
    end else if (cmd_i.push_link && !push_empty && (push_tail < ID_W'(LINK_DEPTH))) begin
      link_we    = 1'b1;
      link_waddr = push_tail[LA_W-1:0];
      link_wdata = push_id;
    end
  end

  tsm_ram #(
    .WIDTH (ID_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (pop_head_d[LA_W-1:0]),
    .rdata_o (link_rdata)
  );

  // slot entry and argument store
  assign cur_is_slot = (cur_q < INIT_ID);
  assign slot_we     = cmd_i.pop_upd && spawn_q;
  assign slot_re     = cmd_i.slot_rd && cur_is_slot;

  tsm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (THREAD_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (popped_q[SA_W-1:0]),
    .wdata_i ({entry_q, arg_q}),
    .re_i    (slot_re),
    .raddr_i (cur_q[SA_W-1:0]),
    .rdata_o (slot_rdata)
  );

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= cmd_in_i;
      m_q     <= mutex_id_i;
      entry_q <= entry_addr_i;
      arg_q   <= arg_value_i;
    end
  end

  // plan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      status_q   <= status_d;
      pop_sel_q  <= pop_sel_d;
      push_sel_q <= push_sel_d;
      spawn_q    <= spawn_d;
      popped_q   <= pop_head_d;
      before_q   <= cur_q;
    end
  end

  // free list and ready queue pointers, current thread, halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_tail_q  <= ID_W'(THREAD_SLOTS - 1);
      ready_head_q <= NIL_ID;
      ready_tail_q <= NIL_ID;
      cur_q        <= INIT_ID;
      halted_q     <= 1'b0;
    end else begin
      if (cmd_i.decide && ((status_d == tsm_pkg::STS_NO_FREE) ||
                           (status_d == tsm_pkg::STS_NO_READY))) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.pop_upd) begin
        if (pop_sel_q == tsm_pkg::Q_FREE) begin
          free_head_q <= pop_nh;
          if (pop_empty) begin
            free_tail_q <= NIL_ID;
          end
        end
        if (pop_sel_q == tsm_pkg::Q_READY) begin
          ready_head_q <= pop_nh;
          if (pop_empty) begin
            ready_tail_q <= NIL_ID;
          end
        end
      end
      if (cmd_i.push_link) begin
        if (push_sel_q == tsm_pkg::Q_FREE) begin
          if (push_empty) begin
            free_head_q <= push_id;
          end
          free_tail_q <= push_id;
        end
        if (push_sel_q == tsm_pkg::Q_READY) begin
          if (push_empty) begin
            ready_head_q <= push_id;
          end
          ready_tail_q <= push_id;
        end
        if (!spawn_q) begin
          cur_q <= popped_q;
        end
      end
    end
  end

  // mutex lock flags and wait queues
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= '0;
      for (int i = 0; i < MUTEX_COUNT; i++) begin
        wait_head_q[i] <= NIL_ID;
        wait_tail_q[i] <= NIL_ID;
      end
    end else begin
      if (cmd_i.decide && lock_set_d) begin
        locked_q[m_idx] <= 1'b1;
      end
      if (cmd_i.decide && lock_clr_d) begin
        locked_q[m_idx] <= 1'b0;
      end
      if (cmd_i.pop_upd && (pop_sel_q == tsm_pkg::Q_WAIT)) begin
        wait_head_q[m_idx] <= pop_nh;
        if (pop_empty) begin
          wait_tail_q[m_idx] <= NIL_ID;
        end
      end
      if (cmd_i.push_link && (push_sel_q == tsm_pkg::Q_WAIT)) begin
        if (push_empty) begin
          wait_head_q[m_idx] <= push_id;
        end
        wait_tail_q[m_idx] <= push_id;
      end
    end
  end

  // link entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (link_we) begin
      link_vld_q[link_waddr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o         <= status_q;
      running_thread_o <= tsm_pkg::RUN_W'(cur_q);
      switched_o       <= (cur_q != before_q);
      spawned_thread_o <= spawn_q ? tsm_pkg::SPAWN_W'(popped_q) : '0;
      running_entry_o  <= cur_is_slot ? slot_rdata[SLOT_W-1:tsm_pkg::ARG_W] : '0;
      running_arg_o    <= cur_is_slot ? signed'(slot_rdata[tsm_pkg::ARG_W-1:0]) : '0;
    end
  end

endmodule

// ----- design/tsm_checker.sv -----
// port-level checks of the thread scheduler, bound to the top level
// depends on tsm_pkg for field widths and status codes
module tsm_checker #(
  parameter int THREAD_SLOTS = tsm_pkg::THREAD_SLOTS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [tsm_pkg::STATUS_W-1:0]     status_o,
  input logic [tsm_pkg::RUN_W-1:0]        running_thread_o,
  input logic                             switched_o,
  input logic [tsm_pkg::SPAWN_W-1:0]      spawned_thread_o,
  input logic [tsm_pkg::ENTRY_W-1:0]      running_entry_o,
  input logic signed [tsm_pkg::ARG_W-1:0] running_arg_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(running_thread_o) && $stable(running_entry_o) && $stable(running_arg_o))
    else $error("stalled result changed");

  // one command at a time: an accept is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a command is in progress");

  // error and halted results never switch threads
  a_err_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tsm_pkg::STS_OK) |-> !switched_o)
    else $error("thread switched on an error result");

  // a nonzero spawned slot only comes with success
  a_spawn_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (spawned_thread_o != '0) |-> (status_o == tsm_pkg::STS_OK))
    else $error("spawned slot reported on a failed command");

  // the initial thread has no stored entry or argument
  a_init_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (THREAD_SLOTS <= 7) &&
      (running_thread_o == tsm_pkg::RUN_W'(THREAD_SLOTS)) |->
      (running_entry_o == '0) && (running_arg_o == '0))
    else $error("initial thread shows a stored entry or argument");

endmodule

bind thread_scheduler_with_mutex_top tsm_checker #(
  .THREAD_SLOTS (THREAD_SLOTS)
) u_tsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .running_thread_o (running_thread_o),
  .switched_o       (switched_o),
  .spawned_thread_o (spawned_thread_o),
  .running_entry_o  (running_entry_o),
  .running_arg_o    (running_arg_o)
);
